// ----- hdl/gelr_pkg.sv -----
// ----------------------------------------------------------------------------
// gelr_pkg
// Shared widths, reset values, register indexes, datapath op codes and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package gelr_pkg;

   localparam int FRAC      = 16;
   localparam int POS_W     = 48;
   localparam int STEP_W    = 32;
   localparam int MUL_W     = 48;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int MUL_STEPS = 4;
   localparam int SQRT_STEPS = PROD_W / 2;
   localparam int DIV_STEPS = FRAC;
   localparam int CNT_W     = 6;
   localparam int IDX_W     = 10;
   localparam int GRID_MAX  = 1023;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPACING  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SIN      = 3'd4;

   localparam logic [11:0] RST_ORIGIN_X = 12'd600;
   localparam logic [11:0] RST_ORIGIN_Y = 12'd100;
   localparam logic [7:0]  RST_SPACING  = 8'd30;
   localparam logic [17:0] RST_COS      = 18'd34428;
   localparam logic [17:0] RST_SIN      = 18'd55765;

   localparam logic [4:0] OP_NONE      = 5'd0;
   localparam logic [4:0] OP_LOAD      = 5'd1;
   localparam logic [4:0] OP_GRID      = 5'd2;
   localparam logic [4:0] OP_MUL_XP    = 5'd3;
   localparam logic [4:0] OP_SUM       = 5'd4;
   localparam logic [4:0] OP_MUL_Y     = 5'd5;
   localparam logic [4:0] OP_STORE_V   = 5'd6;
   localparam logic [4:0] OP_MUL_DX    = 5'd7;
   localparam logic [4:0] OP_SQ1       = 5'd8;
   localparam logic [4:0] OP_MUL_DY    = 5'd9;
   localparam logic [4:0] OP_SQ2       = 5'd10;
   localparam logic [4:0] OP_SQRT_STEP = 5'd11;
   localparam logic [4:0] OP_SQRT_END  = 5'd12;
   localparam logic [4:0] OP_DIV_INIT  = 5'd13;
   localparam logic [4:0] OP_DIV_STEP  = 5'd14;
   localparam logic [4:0] OP_MUL_IX    = 5'd15;
   localparam logic [4:0] OP_MUL_IY    = 5'd16;
   localparam logic [4:0] OP_PX        = 5'd17;
   localparam logic [4:0] OP_TX        = 5'd18;
   localparam logic [4:0] OP_TY        = 5'd19;

   typedef struct packed {
      logic [4:0] op;
      logic       vsel;
      logic       axis;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic line_active;
   } status_type;

endpackage

// ----- hdl/gelr_mul.sv -----
// ----------------------------------------------------------------------------
// gelr_mul
// Unsigned 48x48 multiplier built from four 24x24 partial products, one per
// cycle, accumulated in the next cycle. Sign travels alongside.
// ----------------------------------------------------------------------------
module gelr_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gelr_pkg::MUL_W-1:0]    a,
   input  logic [gelr_pkg::MUL_W-1:0]    b,
   input  logic                          neg,
   output logic [gelr_pkg::PROD_W-1:0]   prod,
   output logic                          prod_neg,
   output logic                          done
);
   import gelr_pkg::*;

   localparam int HW = MUL_W / 2;

   logic [MUL_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic              neg_ff, neg_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [MUL_W-1:0]  pp_ff, pp_in;
   logic [1:0]        psh_ff, psh_in;
   logic              pvld_ff, pvld_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [HW-1:0]     ah, bh;
   logic [PROD_W-1:0] pp_ext;

   always_comb begin
      ah = cnt_ff[1] ? a_ff[MUL_W-1:HW] : a_ff[HW-1:0];
      bh = cnt_ff[0] ? b_ff[MUL_W-1:HW] : b_ff[HW-1:0];
      case (psh_ff)
         2'd0: pp_ext = {{MUL_W{1'b0}}, pp_ff};
         2'd1: pp_ext = {{HW{1'b0}}, pp_ff, {HW{1'b0}}};
         2'd2: pp_ext = {pp_ff, {MUL_W{1'b0}}};
         default: pp_ext = '0;
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      pp_in   = pp_ff;
      psh_in  = psh_ff;
      pvld_in = 1'b0;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         a_in    = a;
         b_in    = b;
         neg_in  = neg;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != 3'(MUL_STEPS)) begin
            pp_in   = ah * bh;
            psh_in  = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
            pvld_in = 1'b1;
            cnt_in  = cnt_ff + 3'd1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (pvld_ff) begin
            acc_in = acc_ff + pp_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      pp_ff  <= pp_in;
      psh_ff <= psh_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         pvld_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         pvld_ff <= pvld_in;
      end
   end

   assign prod     = acc_ff;
   assign prod_neg = neg_ff;
   assign done     = done_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiplier started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("multiplier done longer than one cycle");
`endif

endmodule

// ----- hdl/gelr_dp.sv -----
// ----------------------------------------------------------------------------
// gelr_dp
// Datapath: configuration registers, vertex projection, line length square
// root, per-pixel ratio divider, interpolation and the result register.
// ----------------------------------------------------------------------------
module gelr_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  gelr_pkg::cmd_type                 cmd,
   output gelr_pkg::status_type              status,
   input  logic                              csr_valid,
   input  logic [gelr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gelr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [gelr_pkg::IDX_W-1:0]        req_row,
   input  logic [gelr_pkg::IDX_W-1:0]        req_col,
   input  logic                              req_downward,
   input  logic [15:0]                       req_height_start,
   input  logic [15:0]                       req_height_end,
   output logic [31:0]                       rsp_pixel_x,
   output logic [31:0]                       rsp_pixel_y,
   output logic                              rsp_last_pixel
);
   import gelr_pkg::*;

   function automatic logic [31:0] trunc_int(input logic [POS_W-1:0] p);
      logic [POS_W-1:0] m;
      begin
         m = '0 - p;
         if (p[POS_W-1]) begin
            trunc_int = 32'd0 - m[POS_W-1:FRAC];
         end else begin
            trunc_int = p[POS_W-1:FRAC];
         end
      end
   endfunction

   logic [11:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [7:0]  sp_ff, sp_in;
   logic [17:0] cos_ff, cos_in, sin_ff, sin_in;

   logic [IDX_W-1:0] row_ff, row_in, col_ff, col_in;
   logic             down_ff, down_in;
   logic [15:0]      hs_ff, hs_in, he_ff, he_in;

   logic [19:0]       gx_ff, gx_in, gy_ff, gy_in;
   logic [POS_W-1:0]  sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [POS_W-1:0]  tmp_ff, tmp_in, len_ff, len_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              active_ff, active_in;
   logic [PROD_W-1:0] rad_ff, rad_in;
   logic [49:0]       rem_ff, rem_in;
   logic [POS_W-1:0]  root_ff, root_in;
   logic [POS_W-1:0]  n_ff, n_in;
   logic [FRAC-1:0]   ratio_ff, ratio_in;
   logic [31:0]       tx_ff, tx_in, ox_out_ff, ox_out_in, oy_out_ff, oy_out_in;
   logic              last_ff, last_in;

   logic [10:0]       colv, rowv;
   logic [18:0]       colmul, rowmul;
   logic [20:0]       gd;
   logic [19:0]       gd_mag;
   logic [17:0]       cos_mag, sin_mag;
   logic [POS_W-1:0]  tmp_mag, dx, dy, dx_mag, dy_mag;
   logic              mul_start, mul_neg, prod_neg, mul_done;
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic [PROD_W:0]   sprod;
   logic [51:0]       r4, trial;
   logic [POS_W:0]    n2, nsub;
   logic [STEP_W-1:0] nstep;
   logic [15:0]       hsel;
   logic [POS_W-1:0]  s_sel, off;

   always_comb begin
      colv    = {1'b0, col_ff} + 11'(cmd.vsel & ~down_ff);
      rowv    = {1'b0, row_ff} + 11'(cmd.vsel & down_ff);
      colmul  = sp_ff * colv;
      rowmul  = sp_ff * rowv;
      gd      = {1'b0, gx_ff} - {1'b0, gy_ff};
      gd_mag  = gd[20] ? 20'(21'd0 - gd) : gd[19:0];
      cos_mag = cos_ff[17] ? 18'd0 - cos_ff : cos_ff;
      sin_mag = sin_ff[17] ? 18'd0 - sin_ff : sin_ff;
      tmp_mag = tmp_ff[POS_W-1] ? '0 - tmp_ff : tmp_ff;
      dx      = ex_ff - sx_ff;
      dy      = ey_ff - sy_ff;
      dx_mag  = dx[POS_W-1] ? '0 - dx : dx;
      dy_mag  = dy[POS_W-1] ? '0 - dy : dy;
      sprod   = prod_neg ? '0 - {1'b0, prod} : {1'b0, prod};
      r4      = {rem_ff, rad_ff[PROD_W-1:PROD_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      n2      = {n_ff, 1'b0};
      nsub    = n2 - {1'b0, len_ff};
      nstep   = step_ff + 32'd1;
      hsel    = cmd.vsel ? he_ff : hs_ff;
      s_sel   = cmd.axis ? sy_ff : sx_ff;
      off     = prod[POS_W+FRAC-1:FRAC];
   end

   always_comb begin
      mul_start = 1'b1;
      mul_a     = '0;
      mul_b     = '0;
      mul_neg   = 1'b0;
      case (cmd.op)
         OP_MUL_XP: begin
            mul_a   = MUL_W'(gd_mag);
            mul_b   = MUL_W'(cos_mag);
            mul_neg = gd[20] ^ cos_ff[17];
         end
         OP_MUL_Y: begin
            mul_a   = tmp_mag;
            mul_b   = MUL_W'(sin_mag);
            mul_neg = tmp_ff[POS_W-1] ^ sin_ff[17];
         end
         OP_MUL_DX: begin
            mul_a = dx_mag;
            mul_b = dx_mag;
         end
         OP_MUL_DY: begin
            mul_a = dy_mag;
            mul_b = dy_mag;
         end
         OP_MUL_IX: begin
            mul_a   = dx_mag;
            mul_b   = MUL_W'(ratio_ff);
            mul_neg = dx[POS_W-1];
         end
         OP_MUL_IY: begin
            mul_a   = dy_mag;
            mul_b   = MUL_W'(ratio_ff);
            mul_neg = dy[POS_W-1];
         end
         default: mul_start = 1'b0;
      endcase
   end

   gelr_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_start),
      .a        (mul_a),
      .b        (mul_b),
      .neg      (mul_neg),
      .prod     (prod),
      .prod_neg (prod_neg),
      .done     (mul_done)
   );

   always_comb begin
      ox_in = ox_ff;
      oy_in = oy_ff;
      sp_in = sp_ff;
      cos_in = cos_ff;
      sin_in = sin_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_ORIGIN_X: ox_in  = csr_wdata[11:0];
            REG_ORIGIN_Y: oy_in  = csr_wdata[11:0];
            REG_SPACING:  sp_in  = csr_wdata[7:0];
            REG_COS:      cos_in = csr_wdata;
            REG_SIN:      sin_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      down_in   = down_ff;
      hs_in     = hs_ff;
      he_in     = he_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      ex_in     = ex_ff;
      ey_in     = ey_ff;
      tmp_in    = tmp_ff;
      len_in    = len_ff;
      step_in   = step_ff;
      active_in = active_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      n_in      = n_ff;
      ratio_in  = ratio_ff;
      tx_in     = tx_ff;
      ox_out_in = ox_out_ff;
      oy_out_in = oy_out_ff;
      last_in   = last_ff;
      case (cmd.op)
         OP_LOAD: begin
            row_in  = (req_row > IDX_W'(GRID_MAX)) ? IDX_W'(GRID_MAX) : req_row;
            col_in  = (req_col > IDX_W'(GRID_MAX)) ? IDX_W'(GRID_MAX) : req_col;
            down_in = req_downward;
            hs_in   = req_height_start;
            he_in   = req_height_end;
         end
         OP_GRID: begin
            gx_in = {8'd0, ox_ff} + {1'b0, colmul};
            gy_in = {8'd0, oy_ff} + {1'b0, rowmul};
         end
         OP_SUM: begin
            tmp_in = sprod[POS_W-1:0] + {12'd0, gy_ff, 16'd0};
            if (cmd.vsel) begin
               ex_in = sprod[POS_W-1:0];
            end else begin
               sx_in = sprod[POS_W-1:0];
            end
         end
         OP_STORE_V: begin
            if (cmd.vsel) begin
               ey_in = {{16{hsel[15]}}, hsel, 16'd0} + sprod[POS_W+FRAC-1:FRAC];
            end else begin
               sy_in = {{16{hsel[15]}}, hsel, 16'd0} + sprod[POS_W+FRAC-1:FRAC];
            end
         end
         OP_SQ1: rad_in = prod;
         OP_SQ2: begin
            rad_in  = rad_ff + prod;
            rem_in  = '0;
            root_in = '0;
         end
         OP_SQRT_STEP: begin
            rad_in = {rad_ff[PROD_W-3:0], 2'b00};
            if (r4 >= trial) begin
               rem_in  = 50'(r4 - trial);
               root_in = {root_ff[POS_W-2:0], 1'b1};
            end else begin
               rem_in  = r4[49:0];
               root_in = {root_ff[POS_W-2:0], 1'b0};
            end
         end
         OP_SQRT_END: begin
            len_in    = root_ff;
            step_in   = '0;
            active_in = |root_ff;
         end
         OP_DIV_INIT: begin
            n_in     = {step_ff, 16'd0};
            ratio_in = '0;
         end
         OP_DIV_STEP: begin
            if (n2 >= {1'b0, len_ff}) begin
               n_in     = nsub[POS_W-1:0];
               ratio_in = {ratio_ff[FRAC-2:0], 1'b1};
            end else begin
               n_in     = n2[POS_W-1:0];
               ratio_in = {ratio_ff[FRAC-2:0], 1'b0};
            end
         end
         OP_PX: tmp_in = prod_neg ? s_sel - off : s_sel + off;
         OP_TX: tx_in = trunc_int(tmp_ff);
         OP_TY: begin
            ox_out_in = tx_ff;
            oy_out_in = trunc_int(tmp_ff);
            step_in   = nstep;
            if ({nstep, 16'd0} >= len_ff) begin
               active_in = 1'b0;
               last_in   = 1'b1;
            end else begin
               last_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      col_ff    <= col_in;
      down_ff   <= down_in;
      hs_ff     <= hs_in;
      he_ff     <= he_in;
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      tmp_ff    <= tmp_in;
      len_ff    <= len_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      n_ff      <= n_in;
      ratio_ff  <= ratio_in;
      tx_ff     <= tx_in;
      ox_out_ff <= ox_out_in;
      oy_out_ff <= oy_out_in;
      last_ff   <= last_in;
      if (reset) begin
         ox_ff     <= RST_ORIGIN_X;
         oy_ff     <= RST_ORIGIN_Y;
         sp_ff     <= RST_SPACING;
         cos_ff    <= RST_COS;
         sin_ff    <= RST_SIN;
         step_ff   <= '0;
         active_ff <= 1'b0;
      end else begin
         ox_ff     <= ox_in;
         oy_ff     <= oy_in;
         sp_ff     <= sp_in;
         cos_ff    <= cos_in;
         sin_ff    <= sin_in;
         step_ff   <= step_in;
         active_ff <= active_in;
      end
   end

   assign status.mul_done    = mul_done;
   assign status.line_active = active_ff;
   assign rsp_pixel_x        = ox_out_ff;
   assign rsp_pixel_y        = oy_out_ff;
   assign rsp_last_pixel     = last_ff;

endmodule

// ----- hdl/gelr_ctrl.sv -----
// ----------------------------------------------------------------------------
// gelr_ctrl
// Sequencer for edge setup and per-pixel steps; owns the input and result
// handshakes.
// ----------------------------------------------------------------------------
module gelr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_func,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  gelr_pkg::status_type  status,
   output gelr_pkg::cmd_type     cmd
);
   import gelr_pkg::*;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_GRID     = 5'd1;
   localparam logic [4:0] S_XP_MUL   = 5'd2;
   localparam logic [4:0] S_XP_WAIT  = 5'd3;
   localparam logic [4:0] S_Y_MUL    = 5'd4;
   localparam logic [4:0] S_Y_WAIT   = 5'd5;
   localparam logic [4:0] S_DX_MUL   = 5'd6;
   localparam logic [4:0] S_DX_WAIT  = 5'd7;
   localparam logic [4:0] S_DY_MUL   = 5'd8;
   localparam logic [4:0] S_DY_WAIT  = 5'd9;
   localparam logic [4:0] S_SQRT     = 5'd10;
   localparam logic [4:0] S_SQRT_END = 5'd11;
   localparam logic [4:0] S_DIV_INIT = 5'd12;
   localparam logic [4:0] S_DIV      = 5'd13;
   localparam logic [4:0] S_IX_MUL   = 5'd14;
   localparam logic [4:0] S_IX_WAIT  = 5'd15;
   localparam logic [4:0] S_TX       = 5'd16;
   localparam logic [4:0] S_IY_MUL   = 5'd17;
   localparam logic [4:0] S_IY_WAIT  = 5'd18;
   localparam logic [4:0] S_TY       = 5'd19;

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             vsel_ff, vsel_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_set, take;

   assign take = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      vsel_in  = vsel_ff;
      rsp_set  = 1'b0;
      cmd.op   = OP_NONE;
      cmd.vsel = vsel_ff;
      cmd.axis = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               if (!req_func) begin
                  vsel_in  = 1'b0;
                  state_in = S_GRID;
               end else if (status.line_active) begin
                  state_in = S_DIV_INIT;
               end
            end
         end
         S_GRID: begin
            cmd.op   = OP_GRID;
            state_in = S_XP_MUL;
         end
         S_XP_MUL: begin
            cmd.op   = OP_MUL_XP;
            state_in = S_XP_WAIT;
         end
         S_XP_WAIT: begin
            if (status.mul_done) begin
               cmd.op   = OP_SUM;
               state_in = S_Y_MUL;
            end
         end
         S_Y_MUL: begin
            cmd.op   = OP_MUL_Y;
            state_in = S_Y_WAIT;
         end
         S_Y_WAIT: begin
            if (status.mul_done) begin
               cmd.op = OP_STORE_V;
               if (vsel_ff) begin
                  state_in = S_DX_MUL;
               end else begin
                  vsel_in  = 1'b1;
                  state_in = S_GRID;
               end
            end
         end
         S_DX_MUL: begin
            cmd.op   = OP_MUL_DX;
            state_in = S_DX_WAIT;
         end
         S_DX_WAIT: begin
            if (status.mul_done) begin
               cmd.op   = OP_SQ1;
               state_in = S_DY_MUL;
            end
         end
         S_DY_MUL: begin
            cmd.op   = OP_MUL_DY;
            state_in = S_DY_WAIT;
         end
         S_DY_WAIT: begin
            if (status.mul_done) begin
               cmd.op   = OP_SQ2;
               cnt_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.op = OP_SQRT_STEP;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_SQRT_END;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SQRT_END: begin
            cmd.op   = OP_SQRT_END;
            state_in = S_IDLE;
         end
         S_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_IX_MUL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IX_MUL: begin
            cmd.op   = OP_MUL_IX;
            state_in = S_IX_WAIT;
         end
         S_IX_WAIT: begin
            if (status.mul_done) begin
               cmd.op   = OP_PX;
               state_in = S_TX;
            end
         end
         S_TX: begin
            cmd.op   = OP_TX;
            state_in = S_IY_MUL;
         end
         S_IY_MUL: begin
            cmd.op   = OP_MUL_IY;
            state_in = S_IY_WAIT;
         end
         S_IY_WAIT: begin
            if (status.mul_done) begin
               cmd.op   = OP_PX;
               cmd.axis = 1'b1;
               state_in = S_TY;
            end
         end
         S_TY: begin
            if (!rsp_valid_ff || take) begin
               cmd.op   = OP_TY;
               rsp_set  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_set | (rsp_valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         vsel_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         vsel_ff      <= vsel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_TY) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while held");
   a_sqrt_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT) |-> (cnt_ff < CNT_W'(SQRT_STEPS)))
      else $error("square root step count out of range");
   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_func && !status.line_active)
      |=> (state_ff == S_IDLE && !rsp_set))
      else $error("step beat without pending line left idle");
`endif

endmodule

// ----- hdl/grid_edge_projected_line_raster_core.sv -----
// ----------------------------------------------------------------------------
// grid_edge_projected_line_raster_core
// Projects a height-map edge to screen space and walks its pixels.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/stall     func, row, col, downward, heights
//   rsp      out  rsp_valid/stall     pixel_x, pixel_y, last_pixel
//   csr      in   csr_valid/ready     index, wdata (ready always high)
//
// Start beat: two projections of two multiplier passes each, two squares,
// then a 48-step square root.
// Step beat: 16-step ratio divider, then two interpolations; the final
// state waits while the output register still holds a pixel.
// One beat in flight; a finished pixel holds in the output register while
// the next beat is accepted. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module grid_edge_projected_line_raster_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [gelr_pkg::IDX_W-1:0]        req_row,
   input  logic [gelr_pkg::IDX_W-1:0]        req_col,
   input  logic                              req_downward,
   input  logic signed [15:0]                req_height_start,
   input  logic signed [15:0]                req_height_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_pixel_x,
   output logic signed [31:0]                rsp_pixel_y,
   output logic                              rsp_last_pixel,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gelr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gelr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gelr_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   gelr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gelr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_downward     (req_downward),
      .req_height_start (req_height_start),
      .req_height_end   (req_height_end),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grid_edge_projected_line_raster_core. A built-in
// edge projector and pixel walker predicts every pixel beat; results are
// compared field by field in order, with random idle gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb;
   import gelr_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;
   localparam int   DRAIN_CYCLES = 200;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_func = 1'b0, req_downward = 1'b0;
   logic [IDX_W-1:0] req_row = '0, req_col = '0;
   logic signed [15:0] req_height_start = '0, req_height_end = '0;
   logic req_stall;
   logic rsp_valid, rsp_last_pixel;
   logic rsp_stall = 1'b1;
   logic signed [31:0] rsp_pixel_x, rsp_pixel_y;
   logic csr_valid = 1'b0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   grid_edge_projected_line_raster_core dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [11:0] org_x, org_y;
   logic [7:0]  spacing;
   logic signed [17:0] cos_c, sin_c;
   longint sx, sy, ex, ey;
   logic [47:0] line_len;
   logic [31:0] step_idx;
   logic        drawing;

   pixel_type pending_pixels[$];
   int mismatches = 0, pixels_seen = 0, edges_sent = 0, beats_sent = 0;
   bit quiet = 1'b0;
   bit rsp_took = 1'b0;
   int rsp_hold = 0;

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic void place_vertex(input longint r, c, h, output longint px, py);
      longint gx, gy, xp, acc;
      gx = longint'(org_x) + longint'(spacing) * c;
      gy = longint'(org_y) + longint'(spacing) * r;
      xp = (gx - gy) * longint'(cos_c);
      acc = xp + (gy <<< FRAC);
      px = xp;
      py = (h <<< FRAC) + ((acc * longint'(sin_c)) >>> FRAC);
   endfunction

   function automatic void project_edge(logic [IDX_W-1:0] row, col, logic down,
                                        logic signed [15:0] hs, he);
      longint r, c, r2, c2;
      logic [127:0] sq, cand, root;
      logic [63:0] mx, my;
      r = (row > GRID_MAX) ? GRID_MAX : row;
      c = (col > GRID_MAX) ? GRID_MAX : col;
      r2 = down ? r + 1 : r;
      c2 = down ? c : c + 1;
      place_vertex(r, c, longint'(hs), sx, sy);
      place_vertex(r2, c2, longint'(he), ex, ey);
      mx = magnitude(ex - sx);
      my = magnitude(ey - sy);
      sq = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my};
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = root | (128'd1 << b);
         if (cand * cand <= sq) root = cand;
      end
      line_len = root[47:0];
      step_idx = '0;
      drawing = (line_len != 0);
   endfunction

   function automatic logic [31:0] lerp_pixel(longint s, e, logic [63:0] ratio);
      longint d, p;
      logic [127:0] prod;
      logic [63:0] off;
      d = e - s;
      prod = {64'd0, magnitude(d)} * {64'd0, ratio};
      off = prod[79:16];
      p = (d < 0) ? s - longint'(off) : s + longint'(off);
      if (p >= 0) return 32'(p >>> FRAC);
      return 32'(-longint'(magnitude(p) >> FRAC));
   endfunction

   function automatic void next_pixel();
      logic [63:0] n, ratio, d;
      pixel_type px;
      d = {16'd0, line_len};
      n = {32'd0, step_idx} << FRAC;
      ratio = '0;
      for (int i = 0; i < FRAC; i++) begin
         n = n << 1;
         ratio = ratio << 1;
         if (n >= d) begin
            n = n - d;
            ratio[0] = 1'b1;
         end
      end
      px.x = lerp_pixel(sx, ex, ratio);
      px.y = lerp_pixel(sy, ey, ratio);
      step_idx = step_idx + 1;
      if (({32'd0, step_idx} << FRAC) >= d) drawing = 1'b0;
      px.last = !drawing;
      pending_pixels.push_back(px);
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_ORIGIN_X: org_x = val[11:0];
         REG_ORIGIN_Y: org_y = val[11:0];
         REG_SPACING:  spacing = val[7:0];
         REG_COS:      cos_c = val;
         REG_SIN:      sin_c = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_beat(logic func, logic [IDX_W-1:0] row, col, logic down,
                            logic signed [15:0] hs, he);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_func = func;
      req_row = row;
      req_col = col;
      req_downward = down;
      req_height_start = hs;
      req_height_end = he;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (func == FUNC_START) begin
         project_edge(row, col, down, hs, he);
         edges_sent++;
      end else if (drawing) begin
         next_pixel();
      end
   endtask

   task automatic start_edge(logic [IDX_W-1:0] row, col, logic down,
                             logic signed [15:0] hs, he);
      send_beat(FUNC_START, row, col, down, hs, he);
   endtask

   task automatic step_beat();
      send_beat(FUNC_STEP, IDX_W'($urandom), IDX_W'($urandom), 1'($urandom),
                16'($urandom), 16'($urandom));
   endtask

   task automatic walk_edge(int cap);
      for (int i = 0; i < cap && drawing; i++) step_beat();
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_took = 1'b1;
         pixels_seen++;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected pixel x=%0d y=%0d last=%0b",
                        rsp_pixel_x, rsp_pixel_y, rsp_last_pixel);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_x !== want.x || rsp_pixel_y !== want.y ||
                rsp_last_pixel !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pixel mismatch: exp x=%0d y=%0d last=%0b got x=%0d y=%0d last=%0b",
                           want.x, want.y, want.last,
                           rsp_pixel_x, rsp_pixel_y, rsp_last_pixel);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_took) begin
         rsp_took = 1'b0;
         rsp_hold = quiet ? 0 : $urandom_range(0, 13);
      end
      if (rsp_hold > 0) begin
         rsp_stall = 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   task automatic test_defaults();
      step_beat();                       // nothing pending after reset
      start_edge(10'd3, 10'd4, 1'b0, 16'sd0, 16'sd0);
      walk_edge(1000);
      step_beat();                       // after last pixel
      start_edge(10'd5, 10'd2, 1'b1, 16'sd20, -16'sd15);
      walk_edge(5);
      start_edge(10'd0, 10'd0, 1'b0, 16'sd7, 16'sd9);   // replaces pending line
      walk_edge(1000);
      wait_idle();
   endtask

   task automatic test_extremes();
      start_edge(10'd1023, 10'd1023, 1'b0, 16'sd32767, -16'sd32768);
      walk_edge(4);
      start_edge(10'd1023, 10'd1023, 1'b1, -16'sd32768, 16'sd32767);
      walk_edge(4);
      start_edge(10'd0, 10'd1023, 1'b1, 16'sd0, 16'sd1);
      walk_edge(3);
      wait_idle();
      write_reg(REG_SPACING, 18'd0);
      start_edge(10'd9, 10'd9, 1'b0, 16'sd5, 16'sd5);    // zero-length edge
      step_beat();
      start_edge(10'd9, 10'd9, 1'b1, 16'sd0, 16'sd3);    // heights only
      walk_edge(10);
      wait_idle();
      write_reg(REG_ORIGIN_X, 18'd4095);
      write_reg(REG_ORIGIN_Y, 18'd0);
      write_reg(REG_SPACING, 18'd255);
      write_reg(REG_COS, 18'h20000);                     // beyond Q1.16 range
      write_reg(REG_SIN, 18'h1FFFF);
      write_reg(REG_SPARE_LO, 18'h3FFFF);                // ignored
      write_reg(REG_SPARE_HI, 18'h15555);
      start_edge(10'd1, 10'd2, 1'b0, 16'sd0, 16'sd0);
      walk_edge(3);
      wait_idle();
      write_reg(REG_ORIGIN_X, 18'd0);
      write_reg(REG_ORIGIN_Y, 18'd4095);
      write_reg(REG_SPACING, 18'd1);
      write_reg(REG_COS, 18'(-65536));
      write_reg(REG_SIN, 18'd65536);
      start_edge(10'd1023, 10'd0, 1'b1, -16'sd100, 16'sd100);
      walk_edge(3);
      wait_idle();
   endtask

   task automatic random_config(bit extreme);
      write_reg(REG_ORIGIN_X, extreme ? 18'd4095 : 18'($urandom_range(0, 4095)));
      write_reg(REG_ORIGIN_Y, extreme ? 18'd4095 : 18'($urandom_range(0, 4095)));
      write_reg(REG_SPACING, extreme ? 18'd255 : 18'($urandom_range(1, 40)));
      write_reg(REG_COS, extreme ? 18'd65536 : 18'($urandom_range(0, 131072) - 65536));
      write_reg(REG_SIN, extreme ? 18'(-65536) : 18'($urandom));
   endtask

   task automatic random_phase(int count);
      int start_beats;
      logic signed [15:0] hs, he;
      start_beats = beats_sent;
      while (beats_sent - start_beats < count) begin
         quiet = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 5) == 0) begin
               hs = 16'($urandom);
               he = 16'($urandom);
            end else begin
               hs = 16'($urandom_range(0, 600) - 300);
               he = 16'($urandom_range(0, 600) - 300);
            end
            start_edge(IDX_W'($urandom), IDX_W'($urandom), 1'($urandom), hs, he);
            walk_edge($urandom_range(1, 40));
         end else if ($urandom_range(0, 1) == 0) begin
            start_edge(IDX_W'($urandom), IDX_W'($urandom), 1'($urandom),
                       16'($urandom), 16'($urandom));
         end else begin
            step_beat();
         end
      end
      quiet = 1'b0;
      wait_idle();
   endtask

   task automatic test_random();
      random_phase(170);
      random_config(1'b0);
      random_phase(170);
      random_config(1'b1);
      random_phase(130);
      random_config(1'b0);
      write_reg(REG_SPACING, 18'd1);
      random_phase(210);
   endtask

   initial begin
      org_x = RST_ORIGIN_X;
      org_y = RST_ORIGIN_Y;
      spacing = RST_SPACING;
      cos_c = RST_COS;
      sin_c = RST_SIN;
      sx = 0; sy = 0; ex = 0; ey = 0;
      line_len = '0;
      step_idx = '0;
      drawing = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_defaults();
      test_extremes();
      test_random();
      $display("Covered %0d beats, %0d edge starts, %0d pixels checked, %0d mismatches.",
               beats_sent, edges_sent, pixels_seen, mismatches);
      if (mismatches == 0 && pending_pixels.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Timed out with %0d pixels outstanding.", pending_pixels.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
